// ===== rtl/awu_pkg.sv =====
// Shared types and constants of the affine image warp unit.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package awu_pkg;

  localparam int PIX_W     = 8;
  localparam int CRD_W     = 8;
  localparam int OP_W      = 2;
  localparam int COEF_W    = 32;
  localparam int NCOEF     = 6;
  localparam int CFG_IDX_W = 3;

  // Opcodes of an input item.
  localparam logic [OP_W-1:0] OP_WR  = 2'd0;
  localparam logic [OP_W-1:0] OP_RD  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MVALID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RC     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CC     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFR   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OFFC   = 3'd7;

  // Slots of a coefficient set; the inverse set uses the same layout.
  localparam int K_RR   = 0;
  localparam int K_RC   = 1;
  localparam int K_CR   = 2;
  localparam int K_CC   = 3;
  localparam int K_OFFR = 4;
  localparam int K_OFFC = 5;

  typedef logic [NCOEF-1:0][COEF_W-1:0] coef_set_t;

  typedef struct packed {
    logic load;
    logic clr_init;
    logic clr_run;
    logic mem_go;
    logic res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            clr_last;
    logic            out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/awu_if.sv =====
// Handshake interfaces of the pixel input channel and the result channel.
// Depends on awu_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface awu_in_if;
  import awu_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [CRD_W-1:0] pixel_row;
  logic [CRD_W-1:0] pixel_col;
  logic [PIX_W-1:0] pixel_value;
  modport source(output valid, opcode, pixel_row, pixel_col, pixel_value, input ready);
  modport sink(input valid, opcode, pixel_row, pixel_col, pixel_value, output ready);
endinterface

interface awu_out_if;
  import awu_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             in_range;
  logic             matrix_error;
  modport source(output valid, pixel_out, in_range, matrix_error, input ready);
  modport sink(input valid, pixel_out, in_range, matrix_error, output ready);
endinterface
`default_nettype wire

// ===== rtl/awu_inv.sv =====
// Inverse matrix unit: determinant by a shared multiplier, then six serial
// restoring divisions with saturation. Depends on awu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module awu_inv #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [awu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire awu_pkg::coef_set_t             coef,
  output logic                                busy,
  output logic                                singular,
  output awu_pkg::coef_set_t                  inv
);
  import awu_pkg::*;

  localparam int NW   = 64 + 2 * FRAC_BITS;
  localparam int CNTW = $clog2(NW);

  localparam logic [2:0] I_IDLE  = 3'd0;
  localparam logic [2:0] I_MUL   = 3'd1;
  localparam logic [2:0] I_CHK   = 3'd2;
  localparam logic [2:0] I_LOAD  = 3'd3;
  localparam logic [2:0] I_DIV   = 3'd4;
  localparam logic [2:0] I_STORE = 3'd5;

  logic [2:0]         st_r;
  logic [2:0]         step_r;
  logic [2:0]         j_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] det_r;
  logic signed [63:0] n4_r;
  logic signed [63:0] n5_r;
  logic [63:0]        md_r;
  logic [NW-1:0]      num_r;
  logic [63:0]        rem_r;
  logic [32:0]        q_r;
  logic               ovf_r;
  logic               neg_r;
  logic [CNTW-1:0]    cnt_r;
  coef_set_t          inv_r;
  logic               singular_r;

  logic               start;
  logic signed [31:0] ma;
  logic signed [31:0] mb;
  logic signed [63:0] num_sel;
  logic [63:0]        num_mag;
  logic [64:0]        r2;
  logic               ge;
  logic [64:0]        r2_sub;
  logic [32:0]        qsat;
  logic [32:0]        qneg;
  logic [31:0]        qres;

  assign start    = cfg_we && (cfg_index >= REG_RR);
  assign busy     = (st_r != I_IDLE);
  assign singular = singular_r;
  assign inv      = inv_r;

  // Operand selection for the determinant and translation terms.
  always_comb begin
    case (step_r)
      3'd0: begin ma = $signed(coef[K_RR]); mb = $signed(coef[K_CC]); end
      3'd1: begin ma = $signed(coef[K_RC]); mb = $signed(coef[K_CR]); end
      3'd2: begin ma = $signed(coef[K_CR]); mb = $signed(coef[K_OFFC]); end
      3'd3: begin ma = $signed(coef[K_CC]); mb = $signed(coef[K_OFFR]); end
      3'd4: begin ma = $signed(coef[K_RC]); mb = $signed(coef[K_OFFR]); end
      3'd5: begin ma = $signed(coef[K_RR]); mb = $signed(coef[K_OFFC]); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    case (j_r)
      3'd0:    num_sel = 64'($signed(coef[K_CC]));
      3'd1:    num_sel = -64'($signed(coef[K_RC]));
      3'd2:    num_sel = -64'($signed(coef[K_CR]));
      3'd3:    num_sel = 64'($signed(coef[K_RR]));
      3'd4:    num_sel = n4_r;
      3'd5:    num_sel = n5_r;
      default: num_sel = '0;
    endcase
    num_mag = num_sel[63] ? 64'(-num_sel) : 64'(num_sel);
  end

  assign r2     = {rem_r, num_r[NW-1]};
  assign ge     = (r2 >= {1'b0, md_r});
  assign r2_sub = r2 - {1'b0, md_r};

  // The running quotient saturates at 2^32 once it has grown past it.
  always_comb begin
    qsat = (ovf_r || (q_r[32] && (q_r[31:0] != '0))) ? 33'h1_0000_0000 : q_r;
    qneg = (qsat > 33'h0_8000_0000) ? 33'h0_8000_0000 : qsat;
    if (neg_r) begin
      qres = 32'(-qneg[31:0]);
    end else begin
      qres = (qsat > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : qsat[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= I_IDLE;
      step_r     <= '0;
      j_r        <= '0;
      inv_r      <= '0;
      singular_r <= 1'b1;
    end else if (start) begin
      st_r   <= I_MUL;
      step_r <= '0;
    end else begin
      case (st_r)
        I_MUL: begin
          prod_r <= 64'(ma * mb);
          case (step_r)
            3'd1:    det_r <= prod_r;
            3'd2:    det_r <= det_r - prod_r;
            3'd3:    n4_r  <= prod_r;
            3'd4:    n4_r  <= n4_r - prod_r;
            3'd5:    n5_r  <= prod_r;
            3'd6:    n5_r  <= n5_r - prod_r;
            default: ;
          endcase
          step_r <= step_r + 3'd1;
          if (step_r == 3'd6) begin
            st_r <= I_CHK;
          end
        end
        I_CHK: begin
          j_r  <= '0;
          md_r <= det_r[63] ? 64'(-det_r) : 64'(det_r);
          if (det_r == '0) begin
            singular_r <= 1'b1;
            inv_r      <= '0;
            st_r       <= I_IDLE;
          end else begin
            singular_r <= 1'b0;
            st_r       <= I_LOAD;
          end
        end
        I_LOAD: begin
          neg_r <= num_sel[63] ^ det_r[63];
          num_r <= (j_r < 3'd4) ? (NW'(num_mag) << (2 * FRAC_BITS))
                                : (NW'(num_mag) << FRAC_BITS);
          rem_r <= '0;
          q_r   <= '0;
          ovf_r <= 1'b0;
          cnt_r <= '0;
          st_r  <= I_DIV;
        end
        I_DIV: begin
          num_r <= num_r << 1;
          rem_r <= ge ? r2_sub[63:0] : r2[63:0];
          q_r   <= {q_r[31:0], ge};
          ovf_r <= ovf_r | q_r[32];
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(NW - 1)) begin
            st_r <= I_STORE;
          end
        end
        I_STORE: begin
          inv_r[j_r] <= qres;
          if (j_r == 3'd5) begin
            st_r <= I_IDLE;
          end else begin
            j_r  <= j_r + 3'd1;
            st_r <= I_LOAD;
          end
        end
        default: st_r <= I_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (st_r == I_MUL) && busy)
    else $error("inverse unit did not start after a coefficient write");
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && singular_r) |-> (inv_r == '0))
    else $error("singular matrix left non-zero inverse coefficients");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == I_DIV) |-> (md_r != '0))
    else $error("division started with a zero determinant");
`endif

endmodule
`default_nettype wire

// ===== rtl/awu_dp.sv =====
// Datapath: configuration registers, coordinate mapping, source and
// destination stores, clear counter and result register. Depends on awu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module awu_dp #(
  parameter int IMG_ROWS  = 256,
  parameter int IMG_COLS  = 256,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire awu_pkg::dp_cmd_t               cmd,
  output awu_pkg::dp_stat_t                   stat,
  input  wire logic [awu_pkg::OP_W-1:0]       in_opcode,
  input  wire logic [awu_pkg::CRD_W-1:0]      in_row,
  input  wire logic [awu_pkg::CRD_W-1:0]      in_col,
  input  wire logic [awu_pkg::PIX_W-1:0]      in_value,
  input  wire logic                           cfg_we,
  input  wire logic [awu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [awu_pkg::COEF_W-1:0]     cfg_data,
  output awu_pkg::coef_set_t                  coef,
  input  wire awu_pkg::coef_set_t             inv,
  input  wire logic                           inv_singular,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [awu_pkg::PIX_W-1:0]           out_pixel,
  output logic                                out_in_range,
  output logic                                out_matrix_error
);
  import awu_pkg::*;

  localparam int RW    = $clog2(IMG_ROWS);
  localparam int CLW   = $clog2(IMG_COLS);
  localparam int AW    = RW + CLW;
  localparam int DEPTH = 1 << AW;
  localparam int PW    = CRD_W + 1 + COEF_W;
  localparam int SUMW  = PW + 2;

  logic               mode_r;
  logic               mvalid_r;
  coef_set_t          coef_r;

  logic [OP_W-1:0]    op_r;
  logic [CRD_W-1:0]   row_r;
  logic [CRD_W-1:0]   col_r;
  logic [PIX_W-1:0]   val_r;
  logic               inside_r;

  logic signed [PW-1:0]   p_yr_r, p_yc_r, p_xr_r, p_xc_r;
  logic signed [SUMW-1:0] y_r, x_r;
  logic                   map_ok_r;

  logic [AW-1:0]      clr_cnt_r;
  logic [PIX_W-1:0]   src_q_r;
  logic [PIX_W-1:0]   dst_q_r;

  logic               out_valid_r;
  logic [PIX_W-1:0]   out_pixel_r;
  logic               out_in_range_r;
  logic               out_matrix_error_r;

  logic [PIX_W-1:0]   src_mem [DEPTH];
  logic [PIX_W-1:0]   dst_mem [DEPTH];

  coef_set_t              k;
  logic signed [SUMW-1:0] s_y, s_x, t_y, t_x;
  logic [SUMW-1:0]        row_w, col_w, in_row_w, in_col_w;
  logic [AW-1:0]          dir_addr, map_addr, dst_waddr;
  logic [PIX_W-1:0]       dst_wdata;
  logic                   src_we, scatter, dst_we;
  logic                   err;

  function automatic logic signed [SUMW-1:0] trunc_fix(input logic signed [SUMW-1:0] s);
    logic [SUMW-1:0] mag;
    mag = s[SUMW-1] ? SUMW'(-s) : SUMW'(s);
    mag = mag >> FRAC_BITS;
    return s[SUMW-1] ? -$signed(mag) : $signed(mag);
  endfunction

  assign coef = coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      mvalid_r <= 1'b0;
      coef_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode_r         <= cfg_data[0];
        REG_MVALID: mvalid_r       <= cfg_data[0];
        REG_RR:     coef_r[K_RR]   <= cfg_data;
        REG_RC:     coef_r[K_RC]   <= cfg_data;
        REG_CR:     coef_r[K_CR]   <= cfg_data;
        REG_CC:     coef_r[K_CC]   <= cfg_data;
        REG_OFFR:   coef_r[K_OFFR] <= cfg_data;
        REG_OFFC:   coef_r[K_OFFC] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_row_w = SUMW'(in_row);
  assign in_col_w = SUMW'(in_col);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_opcode;
      row_r    <= in_row;
      col_r    <= in_col;
      val_r    <= in_value;
      inside_r <= (in_row_w < SUMW'(IMG_ROWS)) && (in_col_w < SUMW'(IMG_COLS));
    end
  end

  // Backward mode maps through the inverse, forward mode through the matrix.
  assign k = mode_r ? inv : coef_r;

  always_ff @(posedge clk) begin
    p_yr_r <= $signed({1'b0, row_r}) * $signed(k[K_RR]);
    p_yc_r <= $signed({1'b0, col_r}) * $signed(k[K_CR]);
    p_xr_r <= $signed({1'b0, row_r}) * $signed(k[K_RC]);
    p_xc_r <= $signed({1'b0, col_r}) * $signed(k[K_CC]);
  end

  always_comb begin
    s_y = SUMW'(p_yr_r) + SUMW'(p_yc_r) + SUMW'($signed(k[K_OFFR]));
    s_x = SUMW'(p_xr_r) + SUMW'(p_xc_r) + SUMW'($signed(k[K_OFFC]));
    t_y = trunc_fix(s_y);
    t_x = trunc_fix(s_x);
  end

  always_ff @(posedge clk) begin
    y_r      <= t_y;
    x_r      <= t_x;
    map_ok_r <= !t_y[SUMW-1] && ($unsigned(t_y) < SUMW'(IMG_ROWS)) &&
                !t_x[SUMW-1] && ($unsigned(t_x) < SUMW'(IMG_COLS));
  end

  assign row_w    = SUMW'(row_r);
  assign col_w    = SUMW'(col_r);
  assign dir_addr = {row_w[RW-1:0], col_w[CLW-1:0]};
  assign map_addr = {y_r[RW-1:0], x_r[CLW-1:0]};

  assign src_we    = cmd.mem_go && (op_r == OP_WR) && inside_r;
  assign scatter   = src_we && !mode_r && mvalid_r && map_ok_r;
  assign dst_we    = cmd.clr_run || scatter;
  assign dst_waddr = cmd.clr_run ? clr_cnt_r : map_addr;
  assign dst_wdata = cmd.clr_run ? '0 : val_r;

  always_ff @(posedge clk) begin
    if (src_we) begin
      src_mem[dir_addr] <= val_r;
    end
    src_q_r <= src_mem[map_addr];
  end

  always_ff @(posedge clk) begin
    if (dst_we) begin
      dst_mem[dst_waddr] <= dst_wdata;
    end
    dst_q_r <= dst_mem[dir_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_init) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_run) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign err = !mvalid_r || (mode_r && inv_singular);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_matrix_error_r <= err;
      out_in_range_r     <= !err && inside_r && mode_r && map_ok_r;
      if (err || !inside_r) begin
        out_pixel_r <= '0;
      end else if (!mode_r) begin
        out_pixel_r <= dst_q_r;
      end else begin
        out_pixel_r <= map_ok_r ? src_q_r : '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel        = out_pixel_r;
  assign out_in_range     = out_in_range_r;
  assign out_matrix_error = out_matrix_error_r;

  assign stat.op       = op_r;
  assign stat.clr_last = (clr_cnt_r == '1);
  assign stat.out_busy = out_valid_r && !out_ready;

endmodule
`default_nettype wire

// ===== rtl/awu_ctrl.sv =====
// Controller state machine: sequences each item through the datapath and
// walks the destination clear. Depends on awu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module awu_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [awu_pkg::OP_W-1:0]  in_opcode,
  input  wire logic                      cfg_we,
  input  wire logic                      inv_busy,
  input  wire awu_pkg::dp_stat_t         stat,
  output awu_pkg::dp_cmd_t               cmd
);
  import awu_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_MEM   = 3'd4;
  localparam logic [2:0] S_RES   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       acc;

  assign in_ready = (state_r == S_IDLE) && !inv_busy && !cfg_we;
  assign acc      = in_valid && in_ready;

  assign cmd.load     = acc;
  assign cmd.clr_init = acc && (in_opcode == OP_CLR);
  assign cmd.clr_run  = (state_r == S_CLEAR);
  assign cmd.mem_go   = (state_r == S_MEM);
  assign cmd.res_load = (state_r == S_RES) && !stat.out_busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (acc) begin
          case (in_opcode)
            OP_WR, OP_RD: state_nxt = S_MUL;
            OP_CLR:       state_nxt = S_CLEAR;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_MUL: state_nxt = S_SUM;
      S_SUM: state_nxt = S_MEM;
      S_MEM: state_nxt = (stat.op == OP_RD) ? S_RES : S_IDLE;
      S_RES: if (!stat.out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Reset enters the clear walk so the destination store starts at zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_read_reaches_res: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_opcode == OP_RD)) |-> ##4 (state_r == S_RES))
    else $error("read transfer did not reach the result state");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("input ready during the clear walk");
  a_res_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> (state_r == S_IDLE))
    else $error("result load did not return to idle");
`endif

endmodule
`default_nettype wire

// ===== rtl/affine_image_warp_unit.sv =====
// Pixel write: multiply, sum and memory states run before the next item is taken.
// Pixel read: those states, then the result is registered once the output is free.
// Clear: one destination entry per cycle, through the whole destination store.
// A coefficient write re-derives the inverse: multiply steps, a determinant check, then
// six serial divisions; no item is taken meanwhile.
// Synchronous active-low reset, followed by a full clear walk of the destination store.
`timescale 1ns / 1ps
`default_nettype none
module affine_image_warp_unit #(
  parameter int IMG_ROWS  = 256,
  parameter int IMG_COLS  = 256,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  awu_in_if.sink                              in_if,
  awu_out_if.source                           out_if,
  input  wire logic                           cfg_we,
  input  wire logic [awu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [awu_pkg::COEF_W-1:0]     cfg_data
);
  import awu_pkg::*;

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  coef_set_t coef;
  coef_set_t inv;
  logic      inv_busy;
  logic      inv_singular;
  logic      in_ready;

  assign in_if.ready = in_ready;

  awu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_ready),
    .in_opcode (in_if.opcode),
    .cfg_we    (cfg_we),
    .inv_busy  (inv_busy),
    .stat      (stat),
    .cmd       (cmd)
  );

  awu_dp #(
    .IMG_ROWS  (IMG_ROWS),
    .IMG_COLS  (IMG_COLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_if.opcode),
    .in_row           (in_if.pixel_row),
    .in_col           (in_if.pixel_col),
    .in_value         (in_if.pixel_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .coef             (coef),
    .inv              (inv),
    .inv_singular     (inv_singular),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_pixel        (out_if.pixel_out),
    .out_in_range     (out_if.in_range),
    .out_matrix_error (out_if.matrix_error)
  );

  awu_inv #(
    .FRAC_BITS (FRAC_BITS)
  ) u_inv (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .coef      (coef),
    .busy      (inv_busy),
    .singular  (inv_singular),
    .inv       (inv)
  );

endmodule
`default_nettype wire

// ===== sim/affine_image_warp_unit_test.sv =====
// Self-checking testbench of affine_image_warp_unit: directed table, then random phases.
// Depends on awu_pkg and the awu_in_if / awu_out_if interfaces; keeps its own pixel stores.
`timescale 1ns / 1ps
module affine_image_warp_unit_test;
  import awu_pkg::*;

  localparam int FRAC = 16;
  localparam int SIDE = 256;
  localparam int INV_SETTLE = 700;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             rng;
    logic             err;
  } px_result_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [COEF_W-1:0]    data;
    logic [OP_W-1:0]      op;
    logic [CRD_W-1:0]     row;
    logic [CRD_W-1:0]     col;
    logic [PIX_W-1:0]     val;
    bit                   typed;
    px_result_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;
  bit calm = 1'b0;
  int n_fail = 0;
  int n_items = 0;
  int n_reads = 0;
  int n_settings = 0;

  awu_in_if in_ch();
  awu_out_if out_ch();

  affine_image_warp_unit uut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block: stores, registers and the derived inverse matrix.
  bit [PIX_W-1:0] src_px [SIDE*SIDE];
  bit             src_set [SIDE*SIDE];
  bit [PIX_W-1:0] dst_px [SIDE*SIDE];
  bit             warp_bwd;
  bit             mat_ok;
  longint         fwd_k [NCOEF];
  longint         inv_k [NCOEF];
  bit             inv_singular;
  bit             hit_seen;
  logic [CRD_W-1:0] hit_row, hit_col;
  px_result_t     pending_px [$];
  stim_row_t      plan [$];

  function automatic longint quot_sat(longint num, int sh, longint den);
    logic [127:0] mn, md, q;
    bit neg;
    neg = (num < 0) != (den < 0);
    mn = 128'(num < 0 ? -num : num) << sh;
    md = 128'(den < 0 ? -den : den);
    q = mn / md;
    if (!neg) return (q > 128'h7FFFFFFF) ? 64'sd2147483647 : longint'(q);
    if (q > 128'h80000000) q = 128'h80000000;
    return -longint'(q);
  endfunction

  function automatic void derive_inverse();
    longint a, b, c, d, e, f, det;
    a = fwd_k[K_RR]; b = fwd_k[K_RC]; c = fwd_k[K_CR]; d = fwd_k[K_CC];
    e = fwd_k[K_OFFR]; f = fwd_k[K_OFFC];
    det = a * d - b * c;
    inv_singular = (det == 0);
    foreach (inv_k[i]) inv_k[i] = 0;
    if (inv_singular) return;
    inv_k[K_RR] = quot_sat(d, 2 * FRAC, det);
    inv_k[K_RC] = quot_sat(-b, 2 * FRAC, det);
    inv_k[K_CR] = quot_sat(-c, 2 * FRAC, det);
    inv_k[K_CC] = quot_sat(a, 2 * FRAC, det);
    inv_k[K_OFFR] = quot_sat(c * f - d * e, FRAC, det);
    inv_k[K_OFFC] = quot_sat(b * e - a * f, FRAC, det);
  endfunction

  // Weighted sum truncated toward zero to a whole pixel position.
  function automatic longint map_pt(longint r, longint c, longint kr, longint kc, longint off);
    longint s;
    s = r * kr + c * kc + off;
    if (s >= 0) return s >>> FRAC;
    return -((-s) >>> FRAC);
  endfunction

  function automatic bit on_image(longint y, longint x);
    return y >= 0 && y < SIDE && x >= 0 && x < SIDE;
  endfunction

  function automatic void shadow_cfg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    case (idx)
      REG_MODE:   warp_bwd = data[0];
      REG_MVALID: mat_ok = data[0];
      REG_RR:     fwd_k[K_RR] = longint'(signed'(data));
      REG_RC:     fwd_k[K_RC] = longint'(signed'(data));
      REG_CR:     fwd_k[K_CR] = longint'(signed'(data));
      REG_CC:     fwd_k[K_CC] = longint'(signed'(data));
      REG_OFFR:   fwd_k[K_OFFR] = longint'(signed'(data));
      default:    fwd_k[K_OFFC] = longint'(signed'(data));
    endcase
    derive_inverse();
  endfunction

  // Applies one transferred item to the shadow; returns the result a read produces.
  function automatic px_result_t warp_step(logic [OP_W-1:0] op, logic [CRD_W-1:0] row,
                                           logic [CRD_W-1:0] col, logic [PIX_W-1:0] val);
    px_result_t res;
    longint y, x;
    res = '0;
    case (op)
      OP_WR: begin
        src_px[{row, col}] = val;
        src_set[{row, col}] = 1'b1;
        if (!warp_bwd && mat_ok) begin
          y = map_pt(row, col, fwd_k[K_RR], fwd_k[K_CR], fwd_k[K_OFFR]);
          x = map_pt(row, col, fwd_k[K_RC], fwd_k[K_CC], fwd_k[K_OFFC]);
          if (on_image(y, x)) begin
            dst_px[y * SIDE + x] = val;
            hit_seen = 1'b1;
            hit_row = CRD_W'(y);
            hit_col = CRD_W'(x);
          end
        end
      end
      OP_CLR: foreach (dst_px[i]) dst_px[i] = '0;
      OP_RD: begin
        if (!mat_ok || (warp_bwd && inv_singular)) begin
          res.err = 1'b1;
        end else if (!warp_bwd) begin
          res.pix = dst_px[{row, col}];
        end else begin
          y = map_pt(row, col, inv_k[K_RR], inv_k[K_CR], inv_k[K_OFFR]);
          x = map_pt(row, col, inv_k[K_RC], inv_k[K_CC], inv_k[K_OFFC]);
          if (on_image(y, x)) begin
            res.pix = src_px[y * SIDE + x];
            res.rng = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic drive_item(logic [OP_W-1:0] op, logic [CRD_W-1:0] row,
                            logic [CRD_W-1:0] col, logic [PIX_W-1:0] val);
    if (!calm) begin
      while ($urandom_range(99) < 9) begin
        in_ch.valid = 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid = 1'b1;
    in_ch.opcode = op;
    in_ch.pixel_row = row;
    in_ch.pixel_col = col;
    in_ch.pixel_value = val;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    n_items++;
  endtask

  task automatic send_item(logic [OP_W-1:0] op, logic [CRD_W-1:0] row, logic [CRD_W-1:0] col,
                           logic [PIX_W-1:0] val, bit typed, px_result_t want);
    px_result_t got;
    longint y, x;
    // A gather must never land on a source pixel that was never written: seed it first.
    if (op == OP_RD && warp_bwd && mat_ok && !inv_singular) begin
      y = map_pt(row, col, inv_k[K_RR], inv_k[K_CR], inv_k[K_OFFR]);
      x = map_pt(row, col, inv_k[K_RC], inv_k[K_CC], inv_k[K_OFFC]);
      if (on_image(y, x) && !src_set[y * SIDE + x]) begin
        drive_item(OP_WR, CRD_W'(y), CRD_W'(x), PIX_W'($urandom));
        void'(warp_step(OP_WR, CRD_W'(y), CRD_W'(x), src_px[y * SIDE + x] ^ 8'h00));
        src_px[y * SIDE + x] = in_ch.pixel_value;
      end
    end
    drive_item(op, row, col, val);
    got = warp_step(op, row, col, val);
    if (op == OP_RD) begin
      pending_px.push_back(typed ? want : got);
      n_reads++;
    end
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending_px.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    shadow_cfg(idx, data);
    // Every coefficient register write restarts the inverse derivation inside the block.
    repeat (INV_SETTLE) @(negedge clk);
  endtask

  function automatic void plan_cfg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    plan.push_back(r);
  endfunction

  function automatic void plan_item(logic [OP_W-1:0] op, logic [CRD_W-1:0] row,
                                    logic [CRD_W-1:0] col, logic [PIX_W-1:0] val,
                                    bit typed = 1'b0, px_result_t want = '0);
    stim_row_t r;
    r = '{default: '0};
    r.op = op; r.row = row; r.col = col; r.val = val;
    r.typed = typed;
    r.want = want;
    plan.push_back(r);
  endfunction

  always @(negedge clk) begin
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    px_result_t exp_px;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_px.size() == 0) begin
        $error("result transfer with no read outstanding");
        n_fail++;
      end else begin
        exp_px = pending_px.pop_front();
        if (out_ch.pixel_out !== exp_px.pix) begin
          $error("pixel_out: expected %0d, got %0d", exp_px.pix, out_ch.pixel_out);
          n_fail++;
        end
        if (out_ch.in_range !== exp_px.rng) begin
          $error("in_range: expected %0b, got %0b", exp_px.rng, out_ch.in_range);
          n_fail++;
        end
        if (out_ch.matrix_error !== exp_px.err) begin
          $error("matrix_error: expected %0b, got %0b", exp_px.err, out_ch.matrix_error);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("affine_image_warp_unit regression: fail");
    $finish;
  end

  initial begin
    bit prev_item;
    int op_pick;
    logic [CRD_W-1:0] r_row, r_col;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_RD;
    in_ch.pixel_row = '0;
    in_ch.pixel_col = '0;
    in_ch.pixel_value = '0;
    out_ch.ready = 1'b0;
    warp_bwd = 1'b0;
    mat_ok = 1'b0;
    hit_seen = 1'b0;
    foreach (fwd_k[i]) fwd_k[i] = 0;
    derive_inverse();

    // Reset state first, then a shifted identity, a clear, a gather, a singular matrix,
    // every coefficient at its extreme and finally a forward write and read.
    plan_item(OP_RD, 8'd0, 8'd0, 8'd0, 1'b1, '{pix: 8'd0, rng: 1'b0, err: 1'b1});
    plan_item(OP_WR, 8'd255, 8'd255, 8'd255);
    plan_cfg(REG_RR, 32'h0001_0000);
    plan_cfg(REG_CC, 32'h0001_0000);
    plan_cfg(REG_OFFR, 32'h0002_0000);
    plan_cfg(REG_OFFC, 32'hFFFD_0000);
    plan_cfg(REG_MVALID, 32'd1);
    plan_item(OP_WR, 8'd10, 8'd10, 8'hAA);
    plan_item(OP_WR, 8'd0, 8'd0, 8'd255);
    plan_item(OP_WR, 8'd255, 8'd0, 8'h55);
    plan_item(OP_WR, 8'd0, 8'd255, 8'h01);
    plan_item(OP_RD, 8'd12, 8'd7, 8'd0, 1'b1, '{pix: 8'hAA, rng: 1'b0, err: 1'b0});
    plan_item(OP_RD, 8'd2, 8'd252, 8'hFF);
    plan_item(OP_RD, 8'd255, 8'd255, 8'd0, 1'b1, '{pix: 8'd0, rng: 1'b0, err: 1'b0});
    plan_item(OP_NONE, 8'd1, 8'd1, 8'd1);
    plan_item(OP_CLR, 8'd0, 8'd0, 8'd0);
    plan_item(OP_RD, 8'd12, 8'd7, 8'd0, 1'b1, '{pix: 8'd0, rng: 1'b0, err: 1'b0});
    plan_cfg(REG_MODE, 32'd1);
    plan_item(OP_RD, 8'd12, 8'd7, 8'd0, 1'b1, '{pix: 8'hAA, rng: 1'b1, err: 1'b0});
    plan_item(OP_RD, 8'd0, 8'd0, 8'd0, 1'b1, '{pix: 8'd0, rng: 1'b0, err: 1'b0});
    plan_item(OP_RD, 8'd255, 8'd255, 8'd0);
    plan_cfg(REG_RR, 32'd0);
    plan_item(OP_RD, 8'd5, 8'd5, 8'd0, 1'b1, '{pix: 8'd0, rng: 1'b0, err: 1'b1});
    plan_cfg(REG_RR, 32'h7FFF_FFFF);
    plan_cfg(REG_RC, 32'h8000_0000);
    plan_cfg(REG_CR, 32'h8000_0000);
    plan_cfg(REG_CC, 32'h7FFF_FFFF);
    plan_cfg(REG_OFFR, 32'h7FFF_FFFF);
    plan_cfg(REG_OFFC, 32'h8000_0000);
    plan_item(OP_RD, 8'd0, 8'd0, 8'd0);
    plan_item(OP_RD, 8'd255, 8'd0, 8'd0);
    plan_cfg(REG_MODE, 32'd0);
    plan_item(OP_WR, 8'd1, 8'd1, 8'd7);
    plan_item(OP_RD, 8'd0, 8'd0, 8'd0);

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    prev_item = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (prev_item) drain();
        write_reg(plan[i].idx, plan[i].data);
        prev_item = 1'b0;
      end else begin
        send_item(plan[i].op, plan[i].row, plan[i].col, plan[i].val,
                  plan[i].typed, plan[i].want);
        prev_item = 1'b1;
      end
    end

    // Random phases: mostly near-identity rotations, shears and shifts that keep
    // mapped pixels on the image, so scatters and gathers land on real data.
    for (int p = 0; p < 6; p++) begin
      drain();
      calm = (p == 2);
      n_settings++;
      write_reg(REG_MODE, COEF_W'(p % 2));
      write_reg(REG_MVALID, (p == 4) ? 32'd0 : 32'd1);
      write_reg(REG_RR, 32'h0001_0000 + $urandom_range(0, 32'h1_0000) - 32'h8000);
      write_reg(REG_RC, $urandom_range(0, 32'hC000) - 32'h6000);
      write_reg(REG_CR, $urandom_range(0, 32'hC000) - 32'h6000);
      write_reg(REG_CC, 32'h0001_0000 + $urandom_range(0, 32'h1_0000) - 32'h8000);
      write_reg(REG_OFFR, $urandom_range(0, 80 << FRAC) - (40 << FRAC));
      write_reg(REG_OFFC, $urandom_range(0, 80 << FRAC) - (40 << FRAC));
      for (int k = 0; k < 125; k++) begin
        op_pick = $urandom_range(999);
        r_row = CRD_W'($urandom);
        r_col = CRD_W'($urandom);
        if (op_pick < 20) begin
          send_item(OP_NONE, r_row, r_col, PIX_W'($urandom), 1'b0, '0);
        end else if (op_pick < 26) begin
          send_item(OP_CLR, r_row, r_col, PIX_W'($urandom), 1'b0, '0);
        end else if (op_pick < 520) begin
          send_item(OP_WR, r_row, r_col, PIX_W'($urandom), 1'b0, '0);
        end else begin
          if (!warp_bwd && hit_seen && $urandom_range(1)) begin
            r_row = hit_row;
            r_col = hit_col;
          end
          send_item(OP_RD, r_row, r_col, PIX_W'($urandom), 1'b0, '0);
        end
      end
      // Closing read so that any clear walk has finished before the next settings.
      send_item(OP_RD, CRD_W'($urandom), CRD_W'($urandom), '0, 1'b0, '0);
    end
    calm = 1'b0;

    drain();
    repeat (50) @(negedge clk);
    $display("Covered %0d transfers in, %0d reads checked, %0d random settings.",
             n_items, n_reads, n_settings);
    $display("Forward scatter, backward gather, clears, singular and extreme matrices.");
    if (n_fail == 0 && pending_px.size() == 0) begin
      $display("affine_image_warp_unit regression: pass");
    end else begin
      $display("affine_image_warp_unit regression: fail");
    end
    $finish;
  end

endmodule
